FILE: hdl/gpa_pkg.sv
// ----------------------------------------------------------------------------
// gpa_pkg
// Shared types and constants for the gated profile averager: widths,
// register indexes, reset values and the controller/datapath interface.
// ----------------------------------------------------------------------------
package gpa_pkg;

    localparam int NUM_BINS_DEF   = 1024;
    localparam int CHANNELS_DEF   = 4;
    localparam int COUNT_BITS_DEF = 16;

    localparam int IN_CH   = 4;
    localparam int BIN_W   = 10;
    localparam int END_W   = 11;
    localparam int SAMP_W  = 32;
    localparam int SUM_W   = 48;
    localparam int TOT_W   = SUM_W + 3;
    localparam int IDX_W   = 3;
    localparam int STEP_W  = $clog2(TOT_W);

    localparam logic [SAMP_W-1:0] LIMIT0_RST = 32'd402653;
    localparam logic [SAMP_W-1:0] LIMIT1_RST = 32'd805306368;
    localparam logic [SAMP_W-1:0] LIMIT2_RST = 32'd402653184;
    localparam logic [SAMP_W-1:0] LIMIT3_RST = 32'd134217728;
    localparam logic [BIN_W-1:0]  FIRST_RST  = 10'd30;
    localparam logic [END_W-1:0]  END_RST    = 11'd800;

    typedef enum logic [IDX_W-1:0] {
        REG_LIMIT0 = 3'd0,
        REG_LIMIT1 = 3'd1,
        REG_LIMIT2 = 3'd2,
        REG_LIMIT3 = 3'd3,
        REG_FIRST  = 3'd4,
        REG_END    = 3'd5
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ACC_RD,
        S_ACC_WR,
        S_RD_CHK,
        S_FETCH,
        S_DRAIN,
        S_LOAD,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic clr;
        logic load;
        logic acc_wr;
        logic rd_init;
        logic fetch;
        logic div_load;
        logic div_step;
        logic out_stb;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic edge_bin;
        logic fetch_last;
        logic div_last;
    } t_stat;

endpackage

FILE: hdl/gated_profile_averager_core.sv
// Accumulate word: accepted in idle, then a read state and a write state; the next word is taken back in idle.
// Read word: 5 bin fetches from the sum memory plus a 51-step bit-serial
// divide, both skipped for an edge bin; o_done strobes one cycle, next word may follow.
// Synchronous active-low reset; afterwards a clearing pass over all NUM_BINS
// bins zeroes sums and counts while o_busy is high. Results cannot be stalled.
// ----------------------------------------------------------------------------
// gated_profile_averager_core
// Per-bin gated averager of four-channel return profiles with a five-bin
// boxcar readout.
// ----------------------------------------------------------------------------
module gated_profile_averager_core
    import gpa_pkg::*;
#(
    parameter int NUM_BINS   = NUM_BINS_DEF,
    parameter int CHANNELS   = CHANNELS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_idx,
    input  logic [SAMP_W-1:0] i_cfg_data,
    input  logic              i_mode,
    input  logic [BIN_W-1:0]  i_bin_index,
    input  logic [SAMP_W-1:0] i_sample_ch0,
    input  logic [SAMP_W-1:0] i_sample_ch1,
    input  logic [SAMP_W-1:0] i_sample_ch2,
    input  logic [SAMP_W-1:0] i_sample_ch3,
    output logic              o_done,
    output logic [BIN_W-1:0]  o_echo_bin,
    output logic [SAMP_W-1:0] o_mean_ch0,
    output logic [SAMP_W-1:0] o_mean_ch1,
    output logic [SAMP_W-1:0] o_mean_ch2,
    output logic [SAMP_W-1:0] o_mean_ch3,
    output logic [IN_CH-1:0]  o_zero_count_mask,
    output logic [IN_CH-1:0]  o_saturated_mask,
    output logic              o_edge_error
);

    t_cmd                         cmd;
    t_stat                        stat;
    logic [IN_CH-1:0][SAMP_W-1:0] samples;
    logic [IN_CH-1:0][SAMP_W-1:0] means;

    assign samples = {i_sample_ch3, i_sample_ch2, i_sample_ch1, i_sample_ch0};
    assign o_mean_ch0 = means[0];
    assign o_mean_ch1 = means[1];
    assign o_mean_ch2 = means[2];
    assign o_mean_ch3 = means[3];

    gpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_mode  (i_mode),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    gpa_datapath #(
        .NUM_BINS   (NUM_BINS),
        .CHANNELS   (CHANNELS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_mode            (i_mode),
        .i_bin_index       (i_bin_index),
        .i_samples         (samples),
        .o_done            (o_done),
        .o_echo_bin        (o_echo_bin),
        .o_means           (means),
        .o_zero_count_mask (o_zero_count_mask),
        .o_saturated_mask  (o_saturated_mask),
        .o_edge_error      (o_edge_error)
    );

endmodule

FILE: hdl/gpa_ctrl.sv
// ----------------------------------------------------------------------------
// gpa_ctrl
// Sequencer for the averager: clearing pass, accumulate read/modify/write,
// five-bin fetch and the bit-serial divide of a readout.
// ----------------------------------------------------------------------------
module gpa_ctrl
    import gpa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_mode,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    t_state r_state;
    t_state n_state;

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_mode ? S_RD_CHK : S_ACC_RD;
                end
            end
            S_ACC_RD: begin
                n_state = S_ACC_WR;
            end
            S_ACC_WR: begin
                o_cmd.acc_wr = 1'b1;
                n_state      = S_IDLE;
            end
            S_RD_CHK: begin
                o_cmd.rd_init = 1'b1;
                n_state       = i_stat.edge_bin ? S_OUT : S_FETCH;
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                if (i_stat.fetch_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_cmd.out_stb = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/gpa_datapath.sv
// ----------------------------------------------------------------------------
// gpa_datapath
// Configuration registers, per-channel sum and count memories, five-bin
// total, restoring dividers and the registered result word.
// ----------------------------------------------------------------------------
module gpa_datapath
    import gpa_pkg::*;
#(
    parameter int NUM_BINS   = NUM_BINS_DEF,
    parameter int CHANNELS   = CHANNELS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_stat                    o_stat,
    input  logic                     i_cfg_we,
    input  logic [IDX_W-1:0]         i_cfg_idx,
    input  logic [SAMP_W-1:0]        i_cfg_data,
    input  logic                     i_mode,
    input  logic [BIN_W-1:0]         i_bin_index,
    input  logic [IN_CH-1:0][SAMP_W-1:0] i_samples,
    output logic                     o_done,
    output logic [BIN_W-1:0]         o_echo_bin,
    output logic [IN_CH-1:0][SAMP_W-1:0] o_means,
    output logic [IN_CH-1:0]         o_zero_count_mask,
    output logic [IN_CH-1:0]         o_saturated_mask,
    output logic                     o_edge_error
);

    localparam int AW = $clog2(NUM_BINS);
    localparam int XW = ((AW > BIN_W) ? AW : BIN_W) + 1;
    localparam int DW = COUNT_BITS + 3;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [IN_CH-1:0][SAMP_W-1:0] r_limit;
    logic [BIN_W-1:0]             r_first_bin;
    logic [END_W-1:0]             r_end_bin;
    logic [BIN_W-1:0]             r_bin;
    logic                         r_mode;
    logic [IN_CH-1:0][SAMP_W-1:0] r_samp;
    logic [AW-1:0]                r_clr;
    logic [2:0]                   r_k;
    logic [2:0]                   r_kd;
    logic                         r_acc_vld;
    logic [STEP_W-1:0]            r_step;
    logic                         r_edge;
    logic [XW-1:0]                bin_x;
    logic                         in_window;
    logic [AW-1:0]                rd_addr;
    logic [AW-1:0]                wr_addr;
    logic [IN_CH-1:0][SAMP_W-1:0] lane_mean;
    logic [IN_CH-1:0]             lane_zero;
    logic [IN_CH-1:0]             lane_sat;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit[0]  <= LIMIT0_RST;
            r_limit[1]  <= LIMIT1_RST;
            r_limit[2]  <= LIMIT2_RST;
            r_limit[3]  <= LIMIT3_RST;
            r_first_bin <= FIRST_RST;
            r_end_bin   <= END_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_LIMIT0: r_limit[0]  <= i_cfg_data;
                REG_LIMIT1: r_limit[1]  <= i_cfg_data;
                REG_LIMIT2: r_limit[2]  <= i_cfg_data;
                REG_LIMIT3: r_limit[3]  <= i_cfg_data;
                REG_FIRST:  r_first_bin <= i_cfg_data[BIN_W-1:0];
                REG_END:    r_end_bin   <= i_cfg_data[END_W-1:0];
                default: ;
            endcase
        end
    end

    // capture the word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin  <= i_bin_index;
            r_mode <= i_mode;
            r_samp <= i_samples;
        end
    end

    assign bin_x     = XW'(r_bin);
    assign in_window = (bin_x < XW'(NUM_BINS)) && (r_bin >= r_first_bin)
                       && ({1'b0, r_bin} < r_end_bin);

    // sequencing counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= '0;
            r_k       <= '0;
            r_kd      <= '0;
            r_acc_vld <= 1'b0;
            r_step    <= '0;
            r_edge    <= 1'b0;
        end else begin
            r_acc_vld <= i_cmd.fetch;
            r_kd      <= r_k;
            if (i_cmd.clr) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.rd_init) begin
                r_k    <= '0;
                r_edge <= o_stat.edge_bin;
            end else if (i_cmd.fetch) begin
                r_k <= r_k + 1'b1;
            end
            if (i_cmd.div_load) begin
                r_step <= '0;
            end else if (i_cmd.div_step) begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    assign o_stat.clr_last   = (r_clr == AW'(NUM_BINS - 1));
    assign o_stat.edge_bin   = (r_bin < BIN_W'(2))
                               || ((XW + 1)'(bin_x) + (XW + 1)'(2) >= (XW + 1)'(NUM_BINS));
    assign o_stat.fetch_last = (r_k == 3'd4);
    assign o_stat.div_last   = (r_step == STEP_W'(TOT_W - 1));

    // fetch walks bin-2 .. bin+2; otherwise read the centre bin
    assign rd_addr = i_cmd.fetch ? AW'(bin_x - XW'(2) + XW'(r_k)) : AW'(bin_x);
    assign wr_addr = i_cmd.clr ? r_clr : AW'(bin_x);

    for (genvar c = 0; c < IN_CH; c++) begin : g_lane
        if (c < CHANNELS) begin : g_used
            logic [SUM_W-1:0]      sum_mem [NUM_BINS];
            logic [COUNT_BITS-1:0] cnt_mem [NUM_BINS];
            logic [SUM_W-1:0]      r_rd_sum;
            logic [COUNT_BITS-1:0] r_rd_cnt;
            logic [TOT_W-1:0]      r_tot;
            logic [COUNT_BITS-1:0] r_cnt;
            logic [DW-1:0]         r_div;
            logic [DW-1:0]         r_rem;
            logic [TOT_W-1:0]      r_q;
            logic                  take;
            logic [SUM_W:0]        sum_inc;
            logic [DW:0]           rem_sh;

            // gate the sample on value, limit, window and count
            assign take = i_cmd.acc_wr && in_window && (r_samp[c] != '0)
                          && (r_samp[c] < r_limit[c]) && (r_rd_cnt != CNT_MAX);
            assign sum_inc = {1'b0, r_rd_sum} + (SUM_W + 1)'(r_samp[c]);

            // memory ports
            always_ff @(posedge i_clk) begin
                r_rd_sum <= sum_mem[rd_addr];
                r_rd_cnt <= cnt_mem[rd_addr];
                if (i_cmd.clr) begin
                    sum_mem[wr_addr] <= '0;
                    cnt_mem[wr_addr] <= '0;
                end else if (take) begin
                    sum_mem[wr_addr] <= sum_inc[SUM_W] ? '1 : sum_inc[SUM_W-1:0];
                    cnt_mem[wr_addr] <= r_rd_cnt + 1'b1;
                end
            end

            // five-bin total and centre count
            always_ff @(posedge i_clk) begin
                if (i_cmd.rd_init) begin
                    r_tot <= '0;
                end else if (r_acc_vld) begin
                    r_tot <= r_tot + TOT_W'(r_rd_sum);
                    if (r_kd == 3'd2) begin
                        r_cnt <= r_rd_cnt;
                    end
                end
            end

            assign rem_sh = {r_rem, r_q[TOT_W-1]};

            // restoring divide, one quotient bit a cycle
            always_ff @(posedge i_clk) begin
                if (i_cmd.div_load) begin
                    r_div <= {r_cnt, 2'b00} + DW'(r_cnt);
                    r_rem <= '0;
                    r_q   <= r_tot;
                end else if (i_cmd.div_step) begin
                    if (rem_sh >= {1'b0, r_div}) begin
                        r_rem <= DW'(rem_sh - {1'b0, r_div});
                        r_q   <= {r_q[TOT_W-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh[DW-1:0];
                        r_q   <= {r_q[TOT_W-2:0], 1'b0};
                    end
                end
            end

            assign lane_zero[c] = (r_cnt == '0);
            assign lane_sat[c]  = !lane_zero[c] && (r_q[TOT_W-1:SAMP_W] != '0);
            assign lane_mean[c] = lane_zero[c] ? '0 :
                                  lane_sat[c] ? '1 : r_q[SAMP_W-1:0];
        end else begin : g_unused
            assign lane_zero[c] = 1'b0;
            assign lane_sat[c]  = 1'b0;
            assign lane_mean[c] = '0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= i_cmd.out_stb && r_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_stb) begin
            o_echo_bin   <= r_bin;
            o_edge_error <= r_edge;
            if (r_edge) begin
                o_means           <= '0;
                o_zero_count_mask <= '0;
                o_saturated_mask  <= '0;
            end else begin
                o_means           <= lane_mean;
                o_zero_count_mask <= lane_zero;
                o_saturated_mask  <= lane_sat;
            end
        end
    end

endmodule

FILE: hdl/gpa_checker.sv
// ----------------------------------------------------------------------------
// gpa_checker
// Port-level checks on the averager core, bound to the top level.
// ----------------------------------------------------------------------------
module gpa_checker
    import gpa_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_start,
    input logic              i_mode,
    input logic              o_busy,
    input logic              o_done,
    input logic [SAMP_W-1:0] o_mean_ch0,
    input logic [IN_CH-1:0]  o_zero_count_mask,
    input logic [IN_CH-1:0]  o_saturated_mask,
    input logic              o_edge_error
);

    // clearing pass keeps the core busy straight after reset
    a_clear_busy: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |-> o_busy)
        else $error("core not busy after reset");

    // an edge readout carries no means and no flags
    a_edge_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_edge_error |-> (o_mean_ch0 == '0) && (o_zero_count_mask == '0)
                                   && (o_saturated_mask == '0))
        else $error("edge readout with data");

    // a channel is never both empty and saturated
    a_mask_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_zero_count_mask & o_saturated_mask) == '0)
        else $error("zero and saturated flags overlap");

    // readouts are never back to back
    a_done_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("back-to-back results");

    // an accepted accumulate word never yields a result
    a_acc_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy && !i_mode |=> o_busy && !o_done)
        else $error("accumulate produced a result");

endmodule

bind gated_profile_averager_core gpa_checker u_gpa_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_start           (i_start),
    .i_mode            (i_mode),
    .o_busy            (o_busy),
    .o_done            (o_done),
    .o_mean_ch0        (o_mean_ch0),
    .o_zero_count_mask (o_zero_count_mask),
    .o_saturated_mask  (o_saturated_mask),
    .o_edge_error      (o_edge_error)
);
